>>> src/bnlp_pkg.sv
// Package for the based number literal parser: words, status codes,
// control state type, digit decoding.
// Depends on nothing; used by every module of the block.
package bnlp_pkg;

  // default width of the accumulated value
  localparam int unsigned VALUE_BITS_DEF = 32;
  // width of the value field on the result word
  localparam int unsigned OUT_VALUE_W    = 32;
  // radix storage and digit code width
  localparam int unsigned RADIX_W        = 6;

  localparam logic [7:0]         CH_HASH     = 8'h23;
  localparam logic [7:0]         CH_ZERO     = 8'h30;
  localparam logic [7:0]         CH_NINE     = 8'h39;
  localparam logic [7:0]         CH_LOW_A    = 8'h61;
  localparam logic [7:0]         CH_LOW_Z    = 8'h7a;
  localparam logic [RADIX_W-1:0] DIGIT_NONE  = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] LETTER_BASE = 6'd10;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_BASE  = 2'd1,
    ST_BAD_DIGIT = 2'd2,
    ST_TOO_LARGE = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [OUT_VALUE_W-1:0] value;
    status_t                status;
  } out_word_t;

  // parser control state (accumulator kept apart, its width is a parameter)
  typedef struct packed {
    logic               in_digits;
    logic [RADIX_W-1:0] radix;
    status_t            err;
    logic               base_seen;
  } ctl_t;

  localparam ctl_t CTL_RESET = '{in_digits: 1'b0, radix: RADIX_DEC,
                                 err: ST_OK, base_seen: 1'b0};

  // digit value of a character, DIGIT_NONE for anything else
  function automatic logic [RADIX_W-1:0] digit_of(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = '0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        t = c - CH_ZERO;
        digit_of = t[RADIX_W-1:0];
      end else if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
        t = c - CH_LOW_A;
        digit_of = t[RADIX_W-1:0] + LETTER_BASE;
      end else begin
        digit_of = DIGIT_NONE;
      end
    end
  endfunction

endpackage

>>> src/bnlp_step.sv
// Combinational step of the parser: one character against the current
// state gives the next state and, on the last character, the result word.
// Depends on bnlp_pkg.
module bnlp_step #(
  parameter int unsigned VALUE_BITS = bnlp_pkg::VALUE_BITS_DEF
) (
  input  bnlp_pkg::in_word_t              word,
  input  bnlp_pkg::ctl_t                  ctl,
  input  logic [VALUE_BITS-1:0]           accum,
  output bnlp_pkg::ctl_t                  ctl_nxt,
  output logic [VALUE_BITS-1:0]           accum_nxt,
  output bnlp_pkg::out_word_t             result
);

  localparam int unsigned PW = VALUE_BITS + bnlp_pkg::RADIX_W + 1;

  logic [bnlp_pkg::RADIX_W-1:0] dig;
  logic [bnlp_pkg::RADIX_W-1:0] rdx;
  logic [PW-1:0]                prod;
  logic                         ovf;
  logic                         base_ok;
  bnlp_pkg::ctl_t               ctl_c;
  logic [VALUE_BITS-1:0]        acc_c;
  logic [bnlp_pkg::OUT_VALUE_W-1:0] val_c;

  // digit decode and multiply-add with overflow out of the value width
  assign dig  = bnlp_pkg::digit_of(word.ch);
  assign rdx  = (ctl.radix < bnlp_pkg::RADIX_MIN) ? bnlp_pkg::RADIX_DEC : ctl.radix;
  assign prod = PW'(accum) * PW'(rdx) + PW'(dig);
  assign ovf  = |prod[PW-1:VALUE_BITS];

  assign base_ok = ctl.base_seen &&
                   accum >= VALUE_BITS'(bnlp_pkg::RADIX_MIN) &&
                   accum <= VALUE_BITS'(bnlp_pkg::RADIX_MAX);

  // state update for one character
  always_comb begin
    ctl_c = ctl;
    acc_c = accum;
    if (ctl.err == bnlp_pkg::ST_OK) begin
      if (word.ch == bnlp_pkg::CH_HASH) begin
        if (ctl.in_digits) begin
          ctl_c.err = bnlp_pkg::ST_BAD_DIGIT;
        end else if (!base_ok) begin
          ctl_c.err = bnlp_pkg::ST_BAD_BASE;
        end else begin
          ctl_c.radix     = accum[bnlp_pkg::RADIX_W-1:0];
          ctl_c.in_digits = 1'b1;
          acc_c           = '0;
        end
      end else if (dig >= rdx) begin
        ctl_c.err = bnlp_pkg::ST_BAD_DIGIT;
      end else begin
        if (!ctl.in_digits) begin
          ctl_c.base_seen = 1'b1;
        end
        if (ovf) begin
          ctl_c.err = bnlp_pkg::ST_TOO_LARGE;
        end else begin
          acc_c = prod[VALUE_BITS-1:0];
        end
      end
    end
  end

  // value field: low bits of the accumulator, zero-extended when it is narrower
  generate
    if (VALUE_BITS >= bnlp_pkg::OUT_VALUE_W) begin : g_val_cut
      assign val_c = acc_c[bnlp_pkg::OUT_VALUE_W-1:0];
    end else begin : g_val_ext
      assign val_c = {{(bnlp_pkg::OUT_VALUE_W - VALUE_BITS){1'b0}}, acc_c};
    end
  endgenerate

  // result word and return to reset state after the last character
  always_comb begin
    result.status = ctl_c.err;
    result.value  = (ctl_c.err == bnlp_pkg::ST_OK) ? val_c : '0;
    if (word.last) begin
      ctl_nxt   = bnlp_pkg::CTL_RESET;
      accum_nxt = '0;
    end else begin
      ctl_nxt   = ctl_c;
      accum_nxt = acc_c;
    end
  end

endmodule

>>> src/bnlp_out_reg.sv
// Result register of the parser: holds one result word until taken.
// Depends on bnlp_pkg.
module bnlp_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  bnlp_pkg::out_word_t load_word,
  input  logic                out_stall,
  output logic                hold,
  output logic                out_valid,
  output bnlp_pkg::out_word_t out_word
);

  logic                out_vld_r;
  logic                out_vld_nxt;
  bnlp_pkg::out_word_t out_word_r;

  // word held and not taken this cycle
  assign hold = out_vld_r && out_stall;

  // valid flag: set on load, cleared when taken
  always_comb begin
    out_vld_nxt = out_vld_r && out_stall;
    if (load) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (load) begin
      out_word_r <= load_word;
    end
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_word_r;

endmodule

>>> src/based_number_literal_parser.sv
// Top level of the based number literal parser: input register, parser
// state registers, step logic and result register.
// Depends on bnlp_pkg, bnlp_step and bnlp_out_reg.
//
//   channel | ports                          | word
//   --------+--------------------------------+----------------------------
//   input   | in_valid, in_stall, in_word    | ch (8b), last
//   result  | out_valid, out_stall, out_word | value (32b), status (2b)
//
// One character per cycle while not stalled; a word enters the input
// register, is parsed there against the parser state, and its result
// (last character only) is loaded into the result register.
// The state loop through one multiply-add sets the rate.
// Reset clears the parser state (radix ten, no error) and both valid flags.
// A last character waits in the input register while the result register
// holds an untaken word; other characters pass regardless.
module based_number_literal_parser #(
  parameter int unsigned VALUE_BITS = bnlp_pkg::VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bnlp_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output bnlp_pkg::out_word_t out_word
);

  logic                  s1_vld_r;
  bnlp_pkg::in_word_t    s1_word_r;
  logic                  s1_go;
  logic                  s1_fire;
  logic                  in_take;
  logic                  out_hold;

  bnlp_pkg::ctl_t        ctl_r;
  bnlp_pkg::ctl_t        ctl_nxt;
  logic [VALUE_BITS-1:0] accum_r;
  logic [VALUE_BITS-1:0] accum_nxt;
  bnlp_pkg::out_word_t   result;

  // input register handshake
  assign s1_go    = !s1_word_r.last || !out_hold;
  assign s1_fire  = s1_vld_r && s1_go;
  assign in_stall = s1_vld_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_take) begin
      s1_vld_r <= 1'b1;
    end else if (s1_fire) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r <= in_word;
    end
  end

  // parse step
  bnlp_step #(
    .VALUE_BITS(VALUE_BITS)
  ) u_step (
    .word      (s1_word_r),
    .ctl       (ctl_r),
    .accum     (accum_r),
    .ctl_nxt   (ctl_nxt),
    .accum_nxt (accum_nxt),
    .result    (result)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r   <= bnlp_pkg::CTL_RESET;
      accum_r <= '0;
    end else if (s1_fire) begin
      ctl_r   <= ctl_nxt;
      accum_r <= accum_nxt;
    end
  end

  // result register
  bnlp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (s1_fire && s1_word_r.last),
    .load_word (result),
    .out_stall (out_stall),
    .hold      (out_hold),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

`ifndef SYNTHESIS
  // a parsed last character always shows up as a result word
  a_last_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_word_r.last |=> out_valid)
    else $error("last character produced no result word");

  // radix stays within the legal range
  a_radix_range: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.radix >= bnlp_pkg::RADIX_MIN && ctl_r.radix <= bnlp_pkg::RADIX_MAX)
    else $error("radix out of range");

  // base part is always read in decimal
  a_base_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl_r.in_digits |-> ctl_r.radix == bnlp_pkg::RADIX_DEC)
    else $error("base part not in decimal");

  // failed literals carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status != bnlp_pkg::ST_OK |-> out_word.value == '0)
    else $error("nonzero value with error status");
`endif

endmodule
